// ===== sv/uotg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uotg_pkg
// Shared types and constants of the USB device endpoint register block:
// request/result beats, the endpoint memory entry, decoded operations and
// configuration values.
// ============================================================================
package uotg_pkg;

    // Command codes of a request beat
    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_IN_DONE  = 2'd2;
    localparam logic [1:0] CMD_OUT_DONE = 2'd3;

    // Endpoint number width at the largest endpoint count
    localparam int EP_NUM_W = 4;
    localparam int SIZE_W   = 17;

    // Global address map
    localparam logic [11:0] ADDR_RESET_CTL = 12'h010;
    localparam logic [11:0] ADDR_HWCFG2    = 12'h048;
    localparam logic [11:0] ADDR_HWCFG3    = 12'h04C;
    localparam logic [11:0] ADDR_HWCFG4    = 12'h050;
    localparam logic [11:0] IN_BASE        = 12'h900;
    localparam logic [11:0] IN_LAST        = 12'hAFC;
    localparam logic [11:0] OUT_BASE       = 12'hB00;
    localparam logic [11:0] OUT_LAST       = 12'hCFC;

    // Fixed hardware configuration words
    localparam logic [31:0] HWCFG2_WORD = 32'h7a8f60d0;
    localparam logic [31:0] HWCFG3_WORD = 32'h082000e8;
    localparam logic [31:0] HWCFG4_WORD = 32'h01f08024;

    // Register offsets inside one endpoint slot
    localparam logic [4:0] REG_CTRL = 5'h00;
    localparam logic [4:0] REG_STAT = 5'h08;
    localparam logic [4:0] REG_SIZE = 5'h10;
    localparam logic [4:0] REG_DMA  = 5'h14;
    localparam logic [4:0] REG_BUF  = 5'h1C;

    // Control and status bit positions
    localparam int CTL_ENABLE  = 31;
    localparam int CTL_DISABLE = 30;
    localparam int CTL_SETNAK  = 27;
    localparam int CTL_NAKSTS  = 17;
    localparam int ST_NAKEFF   = 6;
    localparam int ST_DISABLED = 1;
    localparam int ST_DONE     = 0;

    // Global mask summary enables
    localparam int GM_IN_BIT  = 18;
    localparam int GM_OUT_BIT = 19;

    typedef struct packed {
        logic [1:0]        command;
        logic [11:0]       address;
        logic [31:0]       write_data;
        logic [2:0]        endpoint;
        logic [SIZE_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [31:0]       read_data;
        logic              irq_line;
        logic              start_request;
        logic              start_is_out;
        logic [2:0]        start_endpoint;
        logic [SIZE_W-1:0] start_length;
        logic [31:0]       start_address;
        logic              access_error;
    } rsp_t;

    typedef struct packed {
        logic [31:0] control;
        logic [6:0]  status;
        logic [31:0] size;
        logic [31:0] dma;
        logic [31:0] buffer;
    } ep_entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_RST,
        OP_CONST,
        OP_CTRL,
        OP_STAT,
        OP_SIZE,
        OP_DMA,
        OP_BUF,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                wr;
        logic                dir;
        logic [EP_NUM_W-1:0] ep;
        logic [31:0]         data;
        logic [SIZE_W-1:0]   amount;
    } item_t;

    typedef struct packed {
        logic [31:0] global_irq_mask;
        logic [31:0] endpoint_irq_mask;
        logic [15:0] tx_fifo_size;
        logic [15:0] rx_fifo_size;
        logic        link_up;
    } cfg_t;

endpackage

// ===== sv/uotg_ep_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uotg_ep_ram
// Endpoint state memory: one entry per direction and endpoint, one write
// port, one read port with registered data. Entries never written read as 0.
// ============================================================================
module uotg_ep_ram #(
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    output uotg_pkg::ep_entry_t   rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  uotg_pkg::ep_entry_t   wr_data
);

    localparam int DEPTH = 1 << IDX_W;

    uotg_pkg::ep_entry_t mem [DEPTH];
    uotg_pkg::ep_entry_t rd_mem_reg;
    logic [DEPTH-1:0]    valid_reg;
    logic                rd_valid_reg;

    // Write entry and fetch read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_idx];
        end
    end

    // Track written entries so reset state reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ===== sv/uotg_cfg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uotg_cfg
// APB configuration registers: interrupt masks, FIFO depths and link state.
// ============================================================================
module uotg_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output uotg_pkg::cfg_t cfg
);

    localparam logic [2:0] CFG_GMASK = 3'd0;
    localparam logic [2:0] CFG_EMASK = 3'd1;
    localparam logic [2:0] CFG_TXSZ  = 3'd2;
    localparam logic [2:0] CFG_RXSZ  = 3'd3;
    localparam logic [2:0] CFG_LINK  = 3'd4;

    uotg_pkg::cfg_t cfg_reg;
    logic           wr_beat;

    assign wr_beat = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_beat)
        begin
            unique case (paddr[4:2])
                CFG_GMASK: cfg_reg.global_irq_mask   <= pwdata;
                CFG_EMASK: cfg_reg.endpoint_irq_mask <= pwdata;
                CFG_TXSZ:  cfg_reg.tx_fifo_size      <= pwdata[15:0];
                CFG_RXSZ:  cfg_reg.rx_fifo_size      <= pwdata[15:0];
                CFG_LINK:  cfg_reg.link_up           <= pwdata[0];
                default:   ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[4:2])
            CFG_GMASK: prdata = cfg_reg.global_irq_mask;
            CFG_EMASK: prdata = cfg_reg.endpoint_irq_mask;
            CFG_TXSZ:  prdata = {16'b0, cfg_reg.tx_fifo_size};
            CFG_RXSZ:  prdata = {16'b0, cfg_reg.rx_fifo_size};
            CFG_LINK:  prdata = {31'b0, cfg_reg.link_up};
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== sv/uotg_exec.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uotg_exec
// Read-modify-write logic for one decoded item: applies the register access
// or transfer-done event to the fetched endpoint entry and forms the result.
// ============================================================================
module uotg_exec (
    input  uotg_pkg::item_t     item,
    input  uotg_pkg::ep_entry_t entry,
    input  uotg_pkg::cfg_t      cfg,
    input  logic                rst_flag,
    output uotg_pkg::ep_entry_t entry_new,
    output logic                entry_we,
    output logic                rst_flag_new,
    output uotg_pkg::rsp_t      rsp
);

    logic [uotg_pkg::SIZE_W-1:0] cur_size;
    logic [uotg_pkg::SIZE_W-1:0] fifo_cap;
    logic [uotg_pkg::SIZE_W-1:0] xfer_len;
    logic [uotg_pkg::SIZE_W-1:0] fin_amt;
    logic [uotg_pkg::SIZE_W-1:0] size_fin;
    logic [31:0]                 dma_sum;
    logic                        dma_on;
    logic [31:0]                 ctl;
    logic [6:0]                  st;
    logic                        go;

    // Cap the transfer by the FIFO depth of its direction
    assign cur_size = entry.size[uotg_pkg::SIZE_W-1:0];
    assign fifo_cap = item.dir ? {1'b0, cfg.rx_fifo_size} : {1'b0, cfg.tx_fifo_size};
    assign xfer_len = (cur_size > fifo_cap) ? fifo_cap : cur_size;

    // Shared size decrement and DMA advance
    assign fin_amt  = (item.op == uotg_pkg::OP_DONE) ? item.amount : xfer_len;
    assign size_fin = cur_size - fin_amt;
    assign dma_sum  = entry.dma + {{(32 - uotg_pkg::SIZE_W){1'b0}}, fin_amt};
    assign dma_on   = (entry.dma != '0);

    // Apply the operation
    always_comb
    begin
        entry_new    = entry;
        entry_we     = 1'b0;
        rst_flag_new = rst_flag;
        rsp          = '0;
        ctl          = item.data;
        st           = entry.status;
        go           = 1'b0;

        case (item.op)
            uotg_pkg::OP_ERR:
            begin
                rsp.access_error = 1'b1;
            end
            uotg_pkg::OP_RST:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = {rst_flag, 31'b0};
                end
                else if (item.data[0])
                begin
                    rst_flag_new = 1'b1;
                end
                else if (item.data == '0)
                begin
                    rst_flag_new = 1'b0;
                end
            end
            uotg_pkg::OP_CONST:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = item.data;
                end
            end
            uotg_pkg::OP_CTRL:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = entry.control;
                end
                else
                begin
                    entry_we = 1'b1;
                    // Set NAK
                    if (ctl[uotg_pkg::CTL_SETNAK])
                    begin
                        ctl[uotg_pkg::CTL_NAKSTS] = 1'b1;
                        st[uotg_pkg::ST_NAKEFF]   = 1'b1;
                        ctl[uotg_pkg::CTL_SETNAK] = 1'b0;
                    end
                    // Disable drops enable
                    if (ctl[uotg_pkg::CTL_DISABLE])
                    begin
                        st[uotg_pkg::ST_DISABLED]  = 1'b1;
                        ctl[uotg_pkg::CTL_DISABLE] = 1'b0;
                        ctl[uotg_pkg::CTL_ENABLE]  = 1'b0;
                    end
                    // OUT transfers wait while the link is down
                    go = ctl[uotg_pkg::CTL_ENABLE] && !(item.dir && !cfg.link_up);
                    if (go)
                    begin
                        if (cfg.link_up)
                        begin
                            rsp.start_request  = 1'b1;
                            rsp.start_is_out   = item.dir;
                            rsp.start_endpoint = item.ep[2:0];
                            rsp.start_length   = xfer_len;
                            rsp.start_address  = entry.dma;
                        end
                        if (!item.dir && dma_on)
                        begin
                            entry_new.dma = dma_sum;
                        end
                        // IN completes at once with no link
                        if (!item.dir && !cfg.link_up)
                        begin
                            entry_new.size[uotg_pkg::SIZE_W-1:0] = size_fin;
                            ctl[uotg_pkg::CTL_ENABLE]            = 1'b0;
                            st[uotg_pkg::ST_DONE]                = 1'b1;
                        end
                    end
                    entry_new.control = ctl;
                    entry_new.status  = st;
                end
            end
            uotg_pkg::OP_STAT:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = {25'b0, entry.status};
                end
                else
                begin
                    entry_we         = 1'b1;
                    entry_new.status = entry.status & ~item.data[6:0];
                end
            end
            uotg_pkg::OP_SIZE:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = entry.size;
                end
                else
                begin
                    entry_we       = 1'b1;
                    entry_new.size = item.data;
                end
            end
            uotg_pkg::OP_DMA:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = entry.dma;
                end
                else
                begin
                    entry_we      = 1'b1;
                    entry_new.dma = item.data;
                end
            end
            uotg_pkg::OP_BUF:
            begin
                if (!item.wr)
                begin
                    rsp.read_data = entry.buffer;
                end
                else
                begin
                    entry_we         = 1'b1;
                    entry_new.buffer = item.data;
                end
            end
            uotg_pkg::OP_DONE:
            begin
                entry_we = 1'b1;
                if (item.dir && dma_on)
                begin
                    entry_new.dma = dma_sum;
                end
                entry_new.size[uotg_pkg::SIZE_W-1:0]       = size_fin;
                entry_new.control[uotg_pkg::CTL_ENABLE]    = 1'b0;
                entry_new.status[uotg_pkg::ST_DONE]        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/usb_otg_endpoint_register_block.sv =====
`timescale 1ns / 1ps
// ============================================================================
// usb_otg_endpoint_register_block
// Endpoint register block of a USB device controller: per-endpoint control,
// interrupt status, transfer size and DMA address for IN and OUT endpoints,
// transfer starts and the masked interrupt summary.
//
//   Channel   Handshake             Payload
//   request   start / busy          request (uotg_pkg::req_t)
//   result    done (1-cycle strobe) result  (uotg_pkg::rsp_t)
//   config    APB psel/penable      paddr, pwdata, prdata
//
// For each item, the accept cycle reads the endpoint entry from the state
// memory (registered read data), and the next cycle (busy high) modifies
// and writes it back. The result is registered and strobes done in the
// cycle after, while the next item may already be accepted. No new item is
// taken while busy is high. Reset is asynchronous; the memory needs no
// clearing pass. The result cannot be stalled.
// ============================================================================
module usb_otg_endpoint_register_block #(
    parameter int ENDPOINTS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  uotg_pkg::req_t  request,
    output logic            done,
    output uotg_pkg::rsp_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int EPW   = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int IDX_W = EPW + 1;
    localparam logic [uotg_pkg::EP_NUM_W:0] EP_LIMIT = (uotg_pkg::EP_NUM_W + 1)'(ENDPOINTS);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg, state_next;
    uotg_pkg::item_t     item_reg, item_next;
    uotg_pkg::rsp_t      result_reg, result_next;
    logic                done_reg, done_next;
    logic                rst_flag_reg, rst_flag_next;
    logic [ENDPOINTS-1:0] in_nz_reg, in_nz_next;
    logic [ENDPOINTS-1:0] out_nz_reg, out_nz_next;

    uotg_pkg::cfg_t      cfg;
    uotg_pkg::ep_entry_t entry_rd;
    uotg_pkg::ep_entry_t entry_new;
    uotg_pkg::rsp_t      exec_rsp;
    logic                entry_we;
    logic                accept;
    logic                wr_en;

    uotg_pkg::item_t               dec;
    logic [11:0]                   win_off;
    logic [uotg_pkg::EP_NUM_W-1:0] dec_ep;
    logic                          in_win;
    logic                          out_win;
    logic [EPW-1:0]                ep_idx;
    logic                          irq;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    uotg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decode the request beat into an endpoint, reset-control or fixed-word operation
    assign in_win  = (request.address >= uotg_pkg::IN_BASE) &&
                     (request.address <= uotg_pkg::IN_LAST);
    assign out_win = (request.address >= uotg_pkg::OUT_BASE) &&
                     (request.address <= uotg_pkg::OUT_LAST);
    assign win_off = request.address - (out_win ? uotg_pkg::OUT_BASE : uotg_pkg::IN_BASE);

    always_comb
    begin
        dec        = '0;
        dec.op     = uotg_pkg::OP_NONE;
        dec.wr     = (request.command == uotg_pkg::CMD_WRITE);
        dec.amount = request.amount;
        dec.data   = request.write_data;
        dec_ep     = '0;

        if (!request.command[1])
        begin
            if (in_win || out_win)
            begin
                dec_ep  = win_off[8:5];
                dec.dir = out_win;
                dec.ep  = dec_ep;
                if ({1'b0, dec_ep} >= EP_LIMIT)
                begin
                    dec.op = uotg_pkg::OP_ERR;
                end
                else
                begin
                    unique case (win_off[4:0])
                        uotg_pkg::REG_CTRL: dec.op = uotg_pkg::OP_CTRL;
                        uotg_pkg::REG_STAT: dec.op = uotg_pkg::OP_STAT;
                        uotg_pkg::REG_SIZE: dec.op = uotg_pkg::OP_SIZE;
                        uotg_pkg::REG_DMA:  dec.op = uotg_pkg::OP_DMA;
                        uotg_pkg::REG_BUF:  dec.op = uotg_pkg::OP_BUF;
                        default:            dec.op = uotg_pkg::OP_ERR;
                    endcase
                end
            end
            else if (request.address == uotg_pkg::ADDR_RESET_CTL)
            begin
                dec.op = uotg_pkg::OP_RST;
            end
            else if (!dec.wr)
            begin
                // Fixed words travel in the data field
                unique case (request.address)
                    uotg_pkg::ADDR_HWCFG2:
                    begin
                        dec.op   = uotg_pkg::OP_CONST;
                        dec.data = uotg_pkg::HWCFG2_WORD;
                    end
                    uotg_pkg::ADDR_HWCFG3:
                    begin
                        dec.op   = uotg_pkg::OP_CONST;
                        dec.data = uotg_pkg::HWCFG3_WORD;
                    end
                    uotg_pkg::ADDR_HWCFG4:
                    begin
                        dec.op   = uotg_pkg::OP_CONST;
                        dec.data = uotg_pkg::HWCFG4_WORD;
                    end
                    default:
                    begin
                        dec.op = uotg_pkg::OP_NONE;
                    end
                endcase
            end
        end
        else
        begin
            dec_ep  = {1'b0, request.endpoint};
            dec.dir = request.command[0];
            dec.ep  = dec_ep;
            dec.op  = ({1'b0, dec_ep} >= EP_LIMIT) ? uotg_pkg::OP_ERR : uotg_pkg::OP_DONE;
        end
    end

    // Endpoint state memory
    assign ep_idx = item_reg.ep[EPW-1:0];
    assign wr_en  = busy && entry_we;

    uotg_ep_ram #(
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  ({dec.dir, dec.ep[EPW-1:0]}),
        .rd_data (entry_rd),
        .wr_en   (wr_en),
        .wr_idx  ({item_reg.dir, ep_idx}),
        .wr_data (entry_new)
    );

    uotg_exec u_exec (
        .item         (item_reg),
        .entry        (entry_rd),
        .cfg          (cfg),
        .rst_flag     (rst_flag_reg),
        .entry_new    (entry_new),
        .entry_we     (entry_we),
        .rst_flag_new (rst_flag_next),
        .rsp          (exec_rsp)
    );

    // Track nonzero status per endpoint for the interrupt summary
    always_comb
    begin
        in_nz_next  = in_nz_reg;
        out_nz_next = out_nz_reg;
        for (int i = 0; i < ENDPOINTS; i++)
        begin
            if (wr_en && (ep_idx == EPW'(i)))
            begin
                if (item_reg.dir)
                begin
                    out_nz_next[i] = |entry_new.status;
                end
                else
                begin
                    in_nz_next[i] = |entry_new.status;
                end
            end
        end
    end

    assign irq = (cfg.global_irq_mask[uotg_pkg::GM_IN_BIT] &&
                  |(in_nz_next & cfg.endpoint_irq_mask[ENDPOINTS-1:0])) ||
                 (cfg.global_irq_mask[uotg_pkg::GM_OUT_BIT] &&
                  |(out_nz_next & cfg.endpoint_irq_mask[16 +: ENDPOINTS]));

    // Sequence: fetch on accept, modify and write back next cycle
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = dec;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                result_next          = exec_rsp;
                result_next.irq_line = irq;
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            item_reg     <= '0;
            result_reg   <= '0;
            done_reg     <= 1'b0;
            rst_flag_reg <= 1'b0;
            in_nz_reg    <= '0;
            out_nz_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            result_reg <= result_next;
            done_reg   <= done_next;
            in_nz_reg  <= in_nz_next;
            out_nz_reg <= out_nz_next;
            if (busy)
            begin
                rst_flag_reg <= rst_flag_next;
            end
        end
    end

endmodule

// ===== sv/uotg_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// uotg_checker
// Port-level checks of the endpoint register block: item timing, result
// consistency and the configuration handshake.
// ============================================================================
module uotg_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input uotg_pkg::rsp_t result,
    input logic           pready
);

    // An accepted item yields its registered result after its execute state
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result beat missing after accepted item");

    // Busy lasts a single cycle per item
    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // Start fields are clear when nothing starts
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.start_request) |->
            (!result.start_is_out && result.start_endpoint == '0 &&
             result.start_length == '0 && result.start_address == '0))
        else $error("start fields set without start request");

    // A faulty access neither returns data nor starts a transfer
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.access_error) |->
            (result.read_data == '0 && !result.start_request))
        else $error("access error with data or transfer start");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind usb_otg_endpoint_register_block uotg_checker u_uotg_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result),
    .pready (pready)
);
